// ===== hw/rtl/rapqt_pkg.sv =====
// ----------------------------------------------------------------------------
// rapqt_pkg
// Shared types and fixed field widths for the range-add / point-query tree.
// ----------------------------------------------------------------------------
package rapqt_pkg;

  // Fixed payload widths
  localparam int POS_W   = 10;
  localparam int DELTA_W = 16;
  localparam int SUM_W   = 32;

  // Item kinds
  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LCHK,
    ST_LWR,
    ST_RCHK,
    ST_RWR,
    ST_QRD,
    ST_QACC,
    ST_QOUT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture a new item
    logic clr_wr;    // write zero at the clear pointer
    logic rd_l;      // read node at left bound
    logic wr_l;      // write back left node, advance left bound
    logic rd_r;      // read node just below right bound
    logic wr_r;      // write back right node, retreat right bound
    logic shift;     // move both bounds up one level
    logic q_rd;      // read query node, move up one level
    logic out_load;  // load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic l_lt_r;
    logic l_odd;
    logic r_odd;
    logic q_is_root;
    logic add_skip;
    logic q_oob;
    logic is_query;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/rapqt_in_if.sv =====
// ----------------------------------------------------------------------------
// rapqt_in_if
// Input item channel: valid/ready with add and query fields.
// ----------------------------------------------------------------------------
interface rapqt_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic [rapqt_pkg::POS_W-1:0]         range_low;
  logic [rapqt_pkg::POS_W-1:0]         range_high;
  logic signed [rapqt_pkg::DELTA_W-1:0] delta;
  logic [rapqt_pkg::POS_W-1:0]         position;

  modport source (output valid, action, range_low, range_high, delta, position,
                  input ready);
  modport sink (input valid, action, range_low, range_high, delta, position,
                output ready);
endinterface

// ===== hw/rtl/rapqt_out_if.sv =====
// ----------------------------------------------------------------------------
// rapqt_out_if
// Result channel: valid/ready with the queried point sum.
// ----------------------------------------------------------------------------
interface rapqt_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rapqt_pkg::SUM_W-1:0] point_sum;

  modport source (output valid, point_sum, input ready);
  modport sink (input valid, point_sum, output ready);
endinterface

// ===== hw/rtl/range_add_point_query_tree_top.sv =====
// Range-add / point-query segment tree over LEAVES positions.
// Query: an in-range position makes log2(LEAVES)+1 reads on the single read port, from
// leaf to root, and then loads the result; an out-of-range one returns zero unread.
// Range add: one read-modify-write per odd bound on each level, until the bounds meet;
// an empty range makes no node access. Input is taken only in idle, one item at a time.
// Reset: a clearing pass writes zero to all 2*LEAVES nodes, one a cycle, before input opens.
// ----------------------------------------------------------------------------
// range_add_point_query_tree_top
// Top level: joins the sequencer and datapath to the item channels.
// ----------------------------------------------------------------------------
module range_add_point_query_tree_top #(
  parameter int LEAVES      = 1024,
  parameter int TOTAL_WIDTH = 32
) (
  input logic        clk,
  input logic        rst,
  rapqt_in_if.sink   in_ch,
  rapqt_out_if.source out_ch
);

  rapqt_pkg::cmd_t   cmd;
  rapqt_pkg::sts_t   sts;
  rapqt_pkg::state_t state;

  // Sequencer
  rapqt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  // Datapath
  rapqt_datapath #(
    .LEAVES      (LEAVES),
    .TOTAL_WIDTH (TOTAL_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .action     (in_ch.action),
    .range_low  (in_ch.range_low),
    .range_high (in_ch.range_high),
    .delta      (in_ch.delta),
    .position   (in_ch.position),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .point_sum  (out_ch.point_sum)
  );

  // No transfer in while the node store is being cleared
  a_no_in_during_clear: assert property (@(posedge clk) disable iff (rst)
    (state == rapqt_pkg::ST_CLEAR) |-> !in_ch.ready)
    else $error("input ready during clearing pass");

  // A result is only loaded at the end of a query
  a_result_from_query: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (state == rapqt_pkg::ST_QOUT))
    else $error("result loaded outside query completion");

  // Node writes never overlap a query walk
  a_no_write_in_query: assert property (@(posedge clk) disable iff (rst)
    (state == rapqt_pkg::ST_QRD || state == rapqt_pkg::ST_QACC)
      |-> !(cmd.wr_l || cmd.wr_r || cmd.clr_wr))
    else $error("node write during query walk");

endmodule

// ===== hw/rtl/rapqt_datapath.sv =====
// ----------------------------------------------------------------------------
// rapqt_datapath
// Node store, range bounds, query walker, accumulator and result register.
// ----------------------------------------------------------------------------
module rapqt_datapath #(
  parameter int LEAVES      = 1024,
  parameter int TOTAL_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rapqt_pkg::cmd_t                       cmd,
  output rapqt_pkg::sts_t                       sts,
  input  logic                                  action,
  input  logic [rapqt_pkg::POS_W-1:0]           range_low,
  input  logic [rapqt_pkg::POS_W-1:0]           range_high,
  input  logic signed [rapqt_pkg::DELTA_W-1:0]  delta,
  input  logic [rapqt_pkg::POS_W-1:0]           position,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [rapqt_pkg::SUM_W-1:0]    point_sum
);

  localparam int DEPTH = 2 * LEAVES;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int MINW  = rapqt_pkg::POS_W + 1;
  localparam int PW    = ((IDX_W > MINW) ? IDX_W : MINW) + 1;
  localparam int OUT_W = rapqt_pkg::SUM_W;
  localparam logic [PW-1:0]    LEAVES_P = PW'(LEAVES);
  localparam logic [PW-1:0]    LAST_POS = PW'(LEAVES - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  logic [TOTAL_WIDTH-1:0] mem [DEPTH];
  logic [TOTAL_WIDTH-1:0] rdata;
  logic [IDX_W-1:0]       raddr;
  logic [IDX_W-1:0]       waddr;
  logic [TOTAL_WIDTH-1:0] wdata;
  logic                   we;

  logic [IDX_W-1:0]              clr_cnt;
  logic [PW-1:0]                 l;
  logic [PW-1:0]                 r;
  logic [PW-1:0]                 q;
  logic [PW-1:0]                 r_dec;
  logic [PW-1:0]                 r_base;
  logic [TOTAL_WIDTH-1:0]        delta_r;
  logic signed [TOTAL_WIDTH-1:0] sum;
  logic                          q_rd_d;

  logic [PW-1:0] lo_ext;
  logic [PW-1:0] hi_ext;
  logic [PW-1:0] hi_clip;
  logic [PW-1:0] pos_ext;

  // Widen input fields and clip the range to the last leaf
  assign lo_ext  = PW'(range_low);
  assign hi_ext  = PW'(range_high);
  assign pos_ext = PW'(position);
  assign hi_clip = (hi_ext > LAST_POS) ? LAST_POS : hi_ext;
  assign r_dec   = r - PW'(1);
  assign r_base  = cmd.wr_r ? r_dec : r;

  // Status toward the controller
  always_comb begin
    sts.clr_done  = (clr_cnt == LAST_IDX);
    sts.l_lt_r    = (l < r);
    sts.l_odd     = l[0];
    sts.r_odd     = r[0];
    sts.q_is_root = (q == PW'(1));
    sts.add_skip  = (range_low > range_high) || (lo_ext >= LEAVES_P);
    sts.q_oob     = (pos_ext >= LEAVES_P);
    sts.is_query  = (action == rapqt_pkg::ACT_QUERY);
    sts.out_free  = !out_valid || out_ready;
  end

  // Memory port selection
  always_comb begin
    priority if (cmd.rd_l) begin
      raddr = l[IDX_W-1:0];
    end else if (cmd.rd_r) begin
      raddr = r_dec[IDX_W-1:0];
    end else begin
      raddr = q[IDX_W-1:0];
    end
    priority if (cmd.clr_wr) begin
      waddr = clr_cnt;
      wdata = '0;
    end else if (cmd.wr_l) begin
      waddr = l[IDX_W-1:0];
      wdata = rdata + delta_r;
    end else begin
      waddr = r_dec[IDX_W-1:0];
      wdata = rdata + delta_r;
    end
    we = cmd.clr_wr | cmd.wr_l | cmd.wr_r;
  end

  // Node store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Clear pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_wr && !sts.clr_done) begin
      clr_cnt <= clr_cnt + IDX_W'(1);
    end
  end

  // Range bounds and query walker
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      l       <= lo_ext + LEAVES_P;
      r       <= hi_clip + LEAVES_P + PW'(1);
      q       <= pos_ext + LEAVES_P;
      delta_r <= TOTAL_WIDTH'(delta);
    end else begin
      if (cmd.shift) begin
        l <= l >> 1;
        r <= r_base >> 1;
      end else if (cmd.wr_l) begin
        l <= l + PW'(1);
      end
      if (cmd.q_rd) begin
        q <= q >> 1;
      end
    end
  end

  // Accumulate each read node into the path sum in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) begin
      q_rd_d <= 1'b0;
    end else begin
      q_rd_d <= cmd.q_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sum <= '0;
    end else if (q_rd_d) begin
      sum <= sum + $signed(rdata);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      point_sum <= OUT_W'(sum);
    end
  end

endmodule

// ===== hw/rtl/rapqt_ctrl.sv =====
// ----------------------------------------------------------------------------
// rapqt_ctrl
// Sequencer: clearing pass, bottom-up range cover walk, query path walk.
// ----------------------------------------------------------------------------
module rapqt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rapqt_pkg::sts_t     sts,
  output rapqt_pkg::cmd_t     cmd,
  output rapqt_pkg::state_t   state
);

  rapqt_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rapqt_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rapqt_pkg::ST_CLEAR: begin
        if (sts.clr_done) state_next = rapqt_pkg::ST_IDLE;
      end
      rapqt_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (sts.is_query) begin
            state_next = sts.q_oob ? rapqt_pkg::ST_QOUT : rapqt_pkg::ST_QRD;
          end else begin
            state_next = sts.add_skip ? rapqt_pkg::ST_IDLE : rapqt_pkg::ST_LCHK;
          end
        end
      end
      rapqt_pkg::ST_LCHK: begin
        priority if (!sts.l_lt_r) begin
          state_next = rapqt_pkg::ST_IDLE;
        end else if (sts.l_odd) begin
          state_next = rapqt_pkg::ST_LWR;
        end else begin
          state_next = rapqt_pkg::ST_RCHK;
        end
      end
      rapqt_pkg::ST_LWR: state_next = rapqt_pkg::ST_RCHK;
      rapqt_pkg::ST_RCHK: begin
        state_next = sts.r_odd ? rapqt_pkg::ST_RWR : rapqt_pkg::ST_LCHK;
      end
      rapqt_pkg::ST_RWR: state_next = rapqt_pkg::ST_LCHK;
      rapqt_pkg::ST_QRD: begin
        if (sts.q_is_root) state_next = rapqt_pkg::ST_QACC;
      end
      rapqt_pkg::ST_QACC: state_next = rapqt_pkg::ST_QOUT;
      rapqt_pkg::ST_QOUT: begin
        if (sts.out_free) state_next = rapqt_pkg::ST_IDLE;
      end
      default: state_next = rapqt_pkg::ST_CLEAR;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      rapqt_pkg::ST_CLEAR: cmd.clr_wr = 1'b1;
      rapqt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      rapqt_pkg::ST_LCHK: cmd.rd_l = sts.l_lt_r && sts.l_odd;
      rapqt_pkg::ST_LWR:  cmd.wr_l = 1'b1;
      rapqt_pkg::ST_RCHK: begin
        cmd.rd_r  = sts.r_odd;
        cmd.shift = !sts.r_odd;
      end
      rapqt_pkg::ST_RWR: begin
        cmd.wr_r  = 1'b1;
        cmd.shift = 1'b1;
      end
      rapqt_pkg::ST_QRD:  cmd.q_rd = 1'b1;
      rapqt_pkg::ST_QACC: cmd = '0;
      rapqt_pkg::ST_QOUT: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
